// ===== hdl/refcounted_handle_table_defines.svh =====
// Assertion macros used by the handle table RTL.
`ifndef REFCOUNTED_HANDLE_TABLE_DEFINES_SVH
`define REFCOUNTED_HANDLE_TABLE_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define RHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("refcounted_handle_table: check failed");

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define RHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("refcounted_handle_table: check failed");

`endif

// ===== hdl/rht_pkg.sv =====
// Types and constants of the reference-counted handle table.
package rht_pkg;

    localparam int CMD_W        = 3;
    localparam int HANDLE_W     = 8;
    localparam int HANDLE_OUT_W = 6;
    localparam int DESC_W       = 32;
    localparam int INIT_SLOTS   = 3;   // slots live after reset

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 3'd0,
        CMD_GET     = 3'd1,
        CMD_CLOSE   = 3'd2,
        CMD_RETAIN  = 3'd3,
        CMD_RELEASE = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                           status;
        logic [HANDLE_OUT_W-1:0]        handle_out;
        logic signed [DESC_W-1:0]       descriptor;
        logic                           close_request;
    } res_t;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam res_t RES_ERROR = '{
        status:        STATUS_ERR,
        handle_out:    '0,
        descriptor:    '0,
        close_request: 1'b0
    };

    localparam res_t RES_OK = '{
        status:        STATUS_OK,
        handle_out:    '0,
        descriptor:    '0,
        close_request: 1'b0
    };

endpackage

// ===== hdl/rht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/refcounted_handle_table.sv =====
// Reference-counted handle table: top level.
//
// The table holds TABLE_SLOTS slots, each a live mark, a 32-bit descriptor
// and a COUNT_BITS reference count, kept in one RAM entry per slot. After
// reset the block writes slots 0-2 (live, descriptors 0-2, count 1) and
// holds s_ready low meanwhile. A bump pointer hands out slots 3 upward;
// slots at or above it have never been written and read as free. Once the
// bump pointer is used up, add searches the RAM for the lowest free slot,
// one entry per cycle, starting from a hint below which every slot is
// known to be live. Requests are handled one at a time and every lookup
// goes through the single RAM read port: a bump add or an error that needs
// no lookup goes straight to the done state, get/close/retain/release read
// the entry, then modify and write it back, and a searching add steps over
// each live slot past the hint (at most TABLE_SLOTS - 1) before it is done.
// A finished response sits in an output register, so the next request is
// taken while the previous response waits for m_ready.
// close_request = 1 tells the outside to close m_descriptor_out; the close
// call itself is not done here.
module refcounted_handle_table #(
    parameter int TABLE_SLOTS = 64,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // request channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [rht_pkg::CMD_W-1:0]             s_cmd,
    input  logic [rht_pkg::HANDLE_W-1:0]          s_handle,
    input  logic signed [rht_pkg::DESC_W-1:0]     s_descriptor_in,
    // response channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_status,
    output logic [rht_pkg::HANDLE_OUT_W-1:0]      m_handle_out,
    output logic signed [rht_pkg::DESC_W-1:0]     m_descriptor_out,
    output logic                                  m_close_request
);

    import rht_pkg::*;

    `include "refcounted_handle_table_defines.svh"

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int PTR_W   = SLOT_W + 1;            // can hold TABLE_SLOTS itself
    localparam int CMP_W   = (PTR_W > HANDLE_W) ? PTR_W : HANDLE_W;
    localparam int ENTRY_W = 1 + DESC_W + COUNT_BITS;

    localparam logic [PTR_W-1:0]  SLOTS_PTR = PTR_W'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [1:0]        INIT_LAST = 2'(INIT_SLOTS - 1);

    typedef struct packed {
        logic                  live;
        logic [DESC_W-1:0]     desc;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t               state_reg,  state_next;
    logic [1:0]           init_reg,   init_next;    // init pass slot
    logic [PTR_W-1:0]     bump_reg,   bump_next;    // next never-used slot
    logic [PTR_W-1:0]     hint_reg,   hint_next;    // all slots below are live
    logic [SLOT_W-1:0]    scan_reg,   scan_next;    // slot whose data is arriving
    cmd_t                 cmd_reg,    cmd_next;
    logic [SLOT_W-1:0]    handle_reg, handle_next;
    logic [DESC_W-1:0]    desc_reg,   desc_next;
    res_t                 res_reg,    res_next;     // response being built
    res_t                 out_reg,    out_next;     // response on the m_ port
    logic                 m_valid_reg, m_valid_next;

    // RAM port signals
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    entry_t               wr_entry;
    entry_t               rd_entry;

    logic                 out_free;
    logic                 lookup_ok;
    cmd_t                 s_cmd_code;

    assign rd_entry   = ram_rdata;
    assign ram_wdata  = wr_entry;
    assign out_free   = !m_valid_reg || m_ready;
    assign s_cmd_code = cmd_t'(s_cmd);
    // handle below the bump pointer: in range and written at least once
    assign lookup_ok  = CMP_W'(s_handle) < CMP_W'(bump_reg);

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = out_reg.status;
    assign m_handle_out     = out_reg.handle_out;
    assign m_descriptor_out = out_reg.descriptor;
    assign m_close_request  = out_reg.close_request;

    rht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Next state, RAM control and response building
    // ---------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        init_next    = init_reg;
        bump_next    = bump_reg;
        hint_next    = hint_reg;
        scan_next    = scan_reg;
        cmd_next     = cmd_reg;
        handle_next  = handle_reg;
        desc_next    = desc_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        ram_we    = 1'b0;
        ram_waddr = '0;
        wr_entry  = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        unique case (state_reg)
            ST_INIT: begin
                // write the three preset slots
                ram_we         = 1'b1;
                ram_waddr      = SLOT_W'(init_reg);
                wr_entry.live  = 1'b1;
                wr_entry.desc  = DESC_W'(init_reg);
                wr_entry.count = COUNT_BITS'(1);
                init_next      = init_reg + 2'd1;
                if (init_reg == INIT_LAST) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_cmd_code;
                    handle_next = SLOT_W'(s_handle);
                    desc_next   = s_descriptor_in;
                    res_next    = RES_ERROR;
                    state_next  = ST_DONE;
                    case (s_cmd_code) inside
                        CMD_ADD: begin
                            if (bump_reg < SLOTS_PTR) begin
                                // fresh slot straight from the bump pointer
                                ram_we              = 1'b1;
                                ram_waddr           = bump_reg[SLOT_W-1:0];
                                wr_entry.live       = 1'b1;
                                wr_entry.desc       = s_descriptor_in;
                                wr_entry.count      = COUNT_BITS'(1);
                                res_next            = RES_OK;
                                res_next.handle_out = HANDLE_OUT_W'(bump_reg);
                                bump_next           = bump_reg + PTR_W'(1);
                                if (hint_reg == bump_reg) begin
                                    hint_next = bump_reg + PTR_W'(1);
                                end
                            end else if (hint_reg != SLOTS_PTR) begin
                                // search for the lowest free slot from the hint
                                ram_re     = 1'b1;
                                ram_raddr  = hint_reg[SLOT_W-1:0];
                                scan_next  = hint_reg[SLOT_W-1:0];
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_GET, CMD_CLOSE, CMD_RETAIN, CMD_RELEASE: begin
                            if (lookup_ok) begin
                                ram_re     = 1'b1;
                                ram_raddr  = SLOT_W'(s_handle);
                                state_next = ST_EXEC;
                            end
                        end
                        default: begin
                            // unknown command: error response
                        end
                    endcase
                end
            end

            ST_EXEC: begin
                res_next   = RES_ERROR;
                state_next = ST_DONE;
                if (rd_entry.live) begin
                    case (cmd_reg)
                        CMD_GET: begin
                            res_next            = RES_OK;
                            res_next.descriptor = rd_entry.desc;
                        end
                        CMD_CLOSE: begin
                            ram_we                 = 1'b1;
                            ram_waddr              = handle_reg;
                            wr_entry.live          = 1'b0;
                            wr_entry.desc          = '1;
                            wr_entry.count         = '0;
                            res_next               = RES_OK;
                            res_next.descriptor    = rd_entry.desc;
                            res_next.close_request = 1'b1;
                            if (PTR_W'(handle_reg) < hint_reg) begin
                                hint_next = PTR_W'(handle_reg);
                            end
                        end
                        CMD_RETAIN: begin
                            if (rd_entry.count != '1) begin
                                ram_we         = 1'b1;
                                ram_waddr      = handle_reg;
                                wr_entry       = rd_entry;
                                wr_entry.count = rd_entry.count + COUNT_BITS'(1);
                                res_next       = RES_OK;
                            end
                        end
                        CMD_RELEASE: begin
                            if (rd_entry.count == COUNT_BITS'(1)) begin
                                // last reference gone: free the slot
                                ram_we                 = 1'b1;
                                ram_waddr              = handle_reg;
                                wr_entry.live          = 1'b0;
                                wr_entry.desc          = '1;
                                wr_entry.count         = '0;
                                res_next               = RES_OK;
                                res_next.descriptor    = rd_entry.desc;
                                res_next.close_request = 1'b1;
                                if (PTR_W'(handle_reg) < hint_reg) begin
                                    hint_next = PTR_W'(handle_reg);
                                end
                            end else if (rd_entry.count != '0) begin
                                ram_we         = 1'b1;
                                ram_waddr      = handle_reg;
                                wr_entry       = rd_entry;
                                wr_entry.count = rd_entry.count - COUNT_BITS'(1);
                                res_next       = RES_OK;
                            end
                        end
                        default: begin
                            // add never comes here
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (!rd_entry.live) begin
                    ram_we              = 1'b1;
                    ram_waddr           = scan_reg;
                    wr_entry.live       = 1'b1;
                    wr_entry.desc       = desc_reg;
                    wr_entry.count      = COUNT_BITS'(1);
                    res_next            = RES_OK;
                    res_next.handle_out = HANDLE_OUT_W'(scan_reg);
                    hint_next           = PTR_W'(scan_reg) + PTR_W'(1);
                    state_next          = ST_DONE;
                end else if (scan_reg == LAST_SLOT) begin
                    // every slot live: table full
                    res_next   = RES_ERROR;
                    hint_next  = SLOTS_PTR;
                    state_next = ST_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = scan_reg + SLOT_W'(1);
                    scan_next = scan_reg + SLOT_W'(1);
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg    <= '0;
            bump_reg    <= PTR_W'(INIT_SLOTS);
            hint_reg    <= PTR_W'(INIT_SLOTS);
            m_valid_reg <= 1'b0;
        end else begin
            init_reg    <= init_next;
            bump_reg    <= bump_next;
            hint_reg    <= hint_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg   <= scan_next;
        cmd_reg    <= cmd_next;
        handle_reg <= handle_next;
        desc_reg   <= desc_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `RHT_ASSERT_NOW(a_bump_in_range, 1'b1, bump_reg <= SLOTS_PTR)
    `RHT_ASSERT_NOW(a_hint_below_bump, 1'b1, hint_reg <= bump_reg)
    `RHT_ASSERT_NOW(a_idle_write_is_add, (state_reg == ST_IDLE) && ram_we, s_valid && (s_cmd == CMD_ADD))
    `RHT_ASSERT_NEXT(a_one_request_at_a_time, s_valid && s_ready, !s_ready)
    `RHT_ASSERT_NOW(a_close_is_success, m_valid && m_close_request, !m_status)

endmodule

// ===== bench/refcounted_handle_table_tb.sv =====
// Self-checking testbench for the reference-counted handle table.
module refcounted_handle_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rht_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int SLOTS          = 64;
    localparam int COUNT_BITS     = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // cmd encodings outside the defined set; the block must reject them
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LAST  = 3'd7;

    // back-to-back retains on one slot
    localparam int RETAIN_BURST   = 24;

    // receiver hold-off used to back the block up into its request port
    localparam int HOLD_CYCLES    = 400;
    // cycles without any handshake before the run is declared hung;
    // well above the hold-off plus a full free-slot scan
    localparam int WATCHDOG_LIMIT = 3000;
    // quiet time after the last response: longer than the slowest request
    localparam int TAIL_CYCLES    = 80;
    localparam int MAX_REPORTS    = 50;

    typedef enum {RX_ALWAYS, RX_PATTERN, RX_BURSTY} rx_mode_t;

    localparam logic [15:0] STALL_PATTERN = 16'b1101_1001_1110_0110;

    // ------------------------------------------------------------------
    // Slot table mirror and response checker.
    // apply_request updates the mirror the moment a request is taken and
    // queues the response the block owes for it; check_response pops the
    // oldest one and compares it field by field.
    // ------------------------------------------------------------------
    class handle_table_checker;
        bit                      live [SLOTS];
        logic signed [DESC_W-1:0] desc [SLOTS];
        logic [COUNT_BITS-1:0]   refs [SLOTS];
        int unsigned             bump;
        res_t                    pending_responses[$];
        int unsigned             errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                live[i] = 1'b0;
                desc[i] = '0;
                refs[i] = '0;
            end
            for (int i = 0; i < INIT_SLOTS; i++) begin
                live[i] = 1'b1;
                desc[i] = i;
                refs[i] = COUNT_BITS'(1);
            end
            bump   = INIT_SLOTS;
            errors = 0;
        endfunction

        // slot freed by close or by the last release: old descriptor goes out
        // with a close request, the slot is poisoned with all ones
        function res_t retire_slot(int s);
            res_t r;
            r               = RES_OK;
            r.descriptor    = desc[s];
            r.close_request = 1'b1;
            live[s]         = 1'b0;
            refs[s]         = '0;
            desc[s]         = '1;
            return r;
        endfunction

        function void apply_request(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] handle,
                                    logic signed [DESC_W-1:0] din);
            res_t r;
            int   s;
            r = RES_ERROR;
            if (cmd == CMD_ADD) begin
                s = -1;
                if (bump < SLOTS) begin
                    s = bump;
                    bump++;
                end else begin
                    // lowest slot that is not live
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!live[i]) s = i;
                end
                if (s >= 0) begin
                    live[s]      = 1'b1;
                    desc[s]      = din;
                    refs[s]      = COUNT_BITS'(1);
                    r            = RES_OK;
                    r.handle_out = s[HANDLE_OUT_W-1:0];
                end
            end else if (handle < SLOTS && live[handle]) begin
                s = handle;
                case (cmd)
                    CMD_GET: begin
                        r            = RES_OK;
                        r.descriptor = desc[s];
                    end
                    CMD_CLOSE: r = retire_slot(s);
                    CMD_RETAIN: begin
                        if (refs[s] != COUNT_MAX) begin
                            refs[s]++;
                            r = RES_OK;
                        end
                    end
                    CMD_RELEASE: begin
                        if (refs[s] != 0) begin
                            refs[s]--;
                            r = (refs[s] == 0) ? retire_slot(s) : RES_OK;
                        end
                    end
                    default: ;
                endcase
            end
            pending_responses.push_back(r);
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: mismatch on %s: got %h, expected %h", $time, field, got, want);
        endtask

        task check_response(res_t got);
            res_t want;
            if (pending_responses.size() == 0) begin
                report("response with no request outstanding", got.descriptor, '0);
                return;
            end
            want = pending_responses.pop_front();
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
            if (got.handle_out !== want.handle_out)
                report("handle_out", 32'(got.handle_out), 32'(want.handle_out));
            if (got.descriptor !== want.descriptor)
                report("descriptor_out", got.descriptor, want.descriptor);
            if (got.close_request !== want.close_request)
                report("close_request", 32'(got.close_request), 32'(want.close_request));
        endtask
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd;
    logic [HANDLE_W-1:0]      s_handle;
    logic signed [DESC_W-1:0] s_descriptor_in;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_status;
    logic [HANDLE_OUT_W-1:0]  m_handle_out;
    logic signed [DESC_W-1:0] m_descriptor_out;
    logic                     m_close_request;

    handle_table_checker table_chk = new();

    rx_mode_t rx_mode     = RX_ALWAYS;
    bit       rx_hold_req = 1'b0;

    refcounted_handle_table #(
        .TABLE_SLOTS (SLOTS),
        .COUNT_BITS  (COUNT_BITS)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_handle         (s_handle),
        .s_descriptor_in  (s_descriptor_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_handle_out     (m_handle_out),
        .m_descriptor_out (m_descriptor_out),
        .m_close_request  (m_close_request)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Request side. Everything is driven on the falling edge; s_ready is
    // looked at right after the rising edge, before the block updates it,
    // so the value seen is the one the handshake used.
    // ------------------------------------------------------------------
    task send_request(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] handle,
                      logic signed [DESC_W-1:0] din);
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_handle        <= handle;
        s_descriptor_in <= din;
        do @(posedge aclk); while (!s_ready);
        table_chk.apply_request(cmd, handle, din);
        @(negedge aclk);
    endtask

    task idle_for(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    function logic signed [DESC_W-1:0] random_descriptor();
        if ($urandom_range(0, 9) != 0) return $urandom();
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '1;
            default: return '0;
        endcase
    endfunction

    // Mostly well-formed traffic: handles aimed at live slots, with a
    // share of stale, out-of-range and unknown-command requests mixed in.
    task make_random_request(int add_pct, int free_pct, output logic [CMD_W-1:0] cmd,
                             output logic [HANDLE_W-1:0] handle,
                             output logic signed [DESC_W-1:0] din);
        int r;
        int start;
        r = $urandom_range(0, 99);
        if (r < 3)
            cmd = CMD_W'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
        else if (r < 3 + add_pct)
            cmd = CMD_ADD;
        else if (r < 3 + add_pct + free_pct)
            cmd = $urandom_range(0, 1) ? CMD_CLOSE : CMD_RELEASE;
        else
            cmd = $urandom_range(0, 1) ? CMD_GET : CMD_RETAIN;

        r = $urandom_range(0, 99);
        if (r < 75) begin
            start  = $urandom_range(0, SLOTS - 1);
            handle = HANDLE_W'(start);
            for (int i = 0; i < SLOTS; i++) begin
                if (table_chk.live[(start + i) % SLOTS]) begin
                    handle = HANDLE_W'((start + i) % SLOTS);
                    break;
                end
            end
        end else if (r < 88) begin
            handle = HANDLE_W'($urandom_range(0, SLOTS - 1));
        end else if (r < 96) begin
            handle = HANDLE_W'($urandom_range(SLOTS, 255));
        end else begin
            handle = HANDLE_W'($urandom_range(0, 255));
        end
        din = random_descriptor();
    endtask

    // ------------------------------------------------------------------
    // Response side: m_ready follows the current mode, except during a
    // requested hold-off, which this process times on its own.
    // ------------------------------------------------------------------
    initial begin
        int run_left;
        bit run_ready;
        int pat_idx;
        m_ready   = 1'b0;
        run_left  = 0;
        run_ready = 1'b1;
        pat_idx   = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                rx_hold_req = 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_PATTERN: begin
                        m_ready <= STALL_PATTERN[pat_idx];
                        pat_idx = (pat_idx + 1) % 16;
                    end
                    default: begin
                        // random runs of ready and stall
                        if (run_left == 0) begin
                            run_ready = ($urandom_range(0, 2) != 0);
                            run_left  = run_ready ? $urandom_range(1, 12)
                                                  : $urandom_range(1, 10);
                        end
                        m_ready <= run_ready;
                        run_left--;
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            table_chk.check_response(res_t'{m_status, m_handle_out, m_descriptor_out,
                                            m_close_request});
    end

    // hang detector: no handshake on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [CMD_W-1:0]         cmd;
        logic [HANDLE_W-1:0]      handle;
        logic signed [DESC_W-1:0] din;
        int                       items;
        int                       add_pct;
        int                       free_pct;
        bit                       gaps;
        int                       burst_left;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_cmd           = CMD_ADD;
        s_handle        = '0;
        s_descriptor_in = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed: preset slots, bad handles, unknown commands ---
        rx_mode = RX_ALWAYS;
        send_request(CMD_GET, 8'd0, 32'sh7FFF_FFFF);
        send_request(CMD_GET, 8'd2, 32'sh8000_0000);
        send_request(CMD_GET, 8'd3, '1);            // beyond bump: not live
        send_request(CMD_GET, 8'd64, '0);           // first bad handle
        send_request(CMD_RETAIN, 8'd255, '1);       // largest bad handle
        send_request(CMD_UNKNOWN_FIRST, 8'd0, '0);
        send_request(CMD_UNKNOWN_LAST, 8'd1, '1);

        // bump adds with extreme descriptors; handle is don't-care on add
        send_request(CMD_ADD, 8'd255, 32'sh8000_0000);
        send_request(CMD_ADD, 8'd0, 32'sh7FFF_FFFF);
        send_request(CMD_ADD, 8'd170, '1);
        send_request(CMD_GET, 8'd3, '0);
        send_request(CMD_GET, 8'd5, '0);

        // retain/release round trip, then the release that frees the slot
        send_request(CMD_RETAIN, 8'd3, '0);
        send_request(CMD_RELEASE, 8'd3, '0);
        send_request(CMD_RELEASE, 8'd3, '0);
        send_request(CMD_RELEASE, 8'd3, '0);        // already freed
        send_request(CMD_CLOSE, 8'd4, '0);
        send_request(CMD_CLOSE, 8'd4, '0);          // double close
        send_request(CMD_GET, 8'd4, '0);
        send_request(CMD_RETAIN, 8'd63, '0);        // top slot, never used
        send_request(CMD_ADD, 8'd85, '0);

        // --- retain burst on slot 1, back to back, then close it ---
        for (int n = 0; n < RETAIN_BURST; n++)
            send_request(CMD_RETAIN, 8'd1, $urandom());
        send_request(CMD_RELEASE, 8'd1, '0);
        send_request(CMD_CLOSE, 8'd1, '0);

        // --- use up the bump range, then the free list, then overflow ---
        rx_mode = RX_PATTERN;
        for (int n = 0; n < 70; n++)
            send_request(CMD_ADD, HANDLE_W'($urandom_range(0, 255)), random_descriptor());
        // free both ends of the table so the scan has to find each
        send_request(CMD_CLOSE, 8'd63, '0);
        send_request(CMD_CLOSE, 8'd0, '0);
        send_request(CMD_ADD, 8'd0, random_descriptor());
        send_request(CMD_ADD, 8'd0, random_descriptor());   // longest scan
        send_request(CMD_ADD, 8'd0, random_descriptor());   // full again
        send_request(CMD_GET, 8'd63, '0);

        // --- random phases: drain, fill, churn, with varying idling ---
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin items = 200; add_pct = 20; free_pct = 50; gaps = 1;
                         rx_mode = RX_BURSTY;  end
                1: begin items = 220; add_pct = 60; free_pct = 10; gaps = 0;
                         rx_mode = RX_ALWAYS;  end
                2: begin items = 200; add_pct = 10; free_pct = 55; gaps = 1;
                         rx_mode = RX_PATTERN; end
                3: begin items = 200; add_pct = 45; free_pct = 40; gaps = 0;
                         rx_mode = RX_BURSTY;
                         // receiver goes quiet while requests keep coming
                         rx_hold_req = 1'b1;   end
                4: begin items = 230; add_pct = 50; free_pct = 30; gaps = 1;
                         rx_mode = RX_PATTERN; end
                default: begin items = 200; add_pct = 35; free_pct = 30; gaps = 1;
                         rx_mode = RX_ALWAYS;  end
            endcase
            burst_left = $urandom_range(1, 20);
            for (int n = 0; n < items; n++) begin
                make_random_request(add_pct, free_pct, cmd, handle, din);
                send_request(cmd, handle, din);
                if (gaps) begin
                    burst_left--;
                    if (burst_left == 0) begin
                        idle_for($urandom_range(1, 8));
                        burst_left = $urandom_range(1, 20);
                    end
                end
            end
        end
        s_valid <= 1'b0;

        while (table_chk.pending_responses.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (table_chk.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
